/* rtl/tavs_pkg.sv */
`default_nettype none

package tavs_pkg;

  // Width of the pixel ports and of the configuration data bus.
  localparam int DATA_W = 32;

  // Transaction opcodes on the input channel.
  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;

  // Pixel formats.
  localparam logic [1:0] FMT_GREY = 2'd0;
  localparam logic [1:0] FMT_YUV  = 2'd1;
  localparam logic [1:0] FMT_RGBA = 2'd2;
  localparam logic [1:0] FMT_PASS = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FORMAT = 2'd2;
  localparam logic [1:0] REG_MODE   = 2'd3;

  // Black in YUV: chroma at mid scale, luma zero.
  localparam logic [DATA_W-1:0] YUV_BLACK = 32'h0000_0080;

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 4;

  typedef enum logic [1:0] {
    CMD_PIXEL,
    CMD_CLEAR,
    CMD_FILL
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [DATA_W-1:0] pixel;
  } q_entry_t;

  typedef struct packed {
    logic [6:0] width;
    logic [6:0] height;
    logic [1:0] fmt;
    logic       mode;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/tavs_front.sv */
`default_nettype none

module tavs_front #(
  parameter int PIXEL_BITS = 32
) (
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [tavs_pkg::DATA_W-1:0]   pixel_i,
  input  wire tavs_pkg::cfg_t                cfg_i,
  input  wire logic                          q_full_i,
  input  wire logic                          hold_i,
  output logic                               push_o,
  output tavs_pkg::q_entry_t                 entry_o
);
  import tavs_pkg::*;

  localparam logic [DATA_W-1:0] FULL_MASK = DATA_W'((64'd1 << PIXEL_BITS) - 64'd1);

  logic              keep;
  logic [DATA_W-1:0] mask;

  // Take a transaction whenever the queue has room and no clearing pass is due.
  assign ready_o = !q_full_i && !hold_i;

  // Classify the opcode; the unused code is accepted and dropped.
  always_comb begin
    keep          = 1'b1;
    entry_o.cmd   = CMD_PIXEL;
    entry_o.pixel = pixel_i & mask;
    case (opcode_i)
      OP_PIXEL: entry_o.cmd = CMD_PIXEL;
      OP_CLEAR: entry_o.cmd = CMD_CLEAR;
      OP_FILL:  entry_o.cmd = CMD_FILL;
      default:  keep = 1'b0;
    endcase
  end

  // Keep only the bits that the pixel format uses.
  always_comb begin
    case (cfg_i.fmt)
      FMT_GREY: mask = FULL_MASK & 32'h0000_00FF;
      FMT_YUV:  mask = FULL_MASK & 32'h0000_FFFF;
      default:  mask = FULL_MASK;
    endcase
  end

  assign push_o = valid_i && ready_o && keep;

endmodule

`default_nettype wire

/* rtl/tavs_queue.sv */
`default_nettype none

module tavs_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_i,
  input  wire tavs_pkg::q_entry_t wdata_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output tavs_pkg::q_entry_t      rdata_o,
  output logic                    empty_o
);
  import tavs_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  q_entry_t         entries [QDEPTH];
  logic [QAW:0]     wr_ptr_r;
  logic [QAW:0]     wr_ptr_nxt;
  logic [QAW:0]     rd_ptr_r;
  logic [QAW:0]     rd_ptr_nxt;

  // Full when the pointers differ only in the wrap bit.
  assign empty_o = (wr_ptr_r == rd_ptr_r);
  assign full_o  = (wr_ptr_r[QAW] != rd_ptr_r[QAW]) &&
                   (wr_ptr_r[QAW-1:0] == rd_ptr_r[QAW-1:0]);
  assign rdata_o = entries[rd_ptr_r[QAW-1:0]];

  assign wr_ptr_nxt = wr_ptr_r + (QAW+1)'(push_i);
  assign rd_ptr_nxt = rd_ptr_r + (QAW+1)'(pop_i);

  // Pointer update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_i) begin
      entries[wr_ptr_r[QAW-1:0]] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/tavs_back.sv */
`default_nettype none

module tavs_back #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int PIXEL_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tavs_pkg::cfg_t              cfg_i,
  input  wire logic                        restart_i,
  input  wire logic                        q_empty_i,
  input  wire tavs_pkg::q_entry_t          q_head_i,
  output logic                             q_pop_o,
  output logic                             clearing_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [tavs_pkg::DATA_W-1:0]      out_pixel_o,
  output logic                             out_row_last_o,
  output logic                             out_frame_last_o
);
  import tavs_pkg::*;

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int RIW       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SLOT_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int DEPTH     = MAX_WIDTH * SLOT_SIZE;
  localparam int AW        = $clog2(DEPTH);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;

  // Store address of one pixel: slot major, then row, then column.
  function automatic logic [AW-1:0] st_addr(input logic [CW-1:0]  s,
                                            input logic [RIW-1:0] r,
                                            input logic [CW-1:0]  c);
    st_addr = AW'((32'(s) * MAX_HEIGHT + 32'(r)) * MAX_WIDTH + 32'(c));
  endfunction

  logic [PIXEL_BITS-1:0] store_mem [DEPTH];
  logic [PIXEL_BITS-1:0] row_mem   [MAX_WIDTH];

  logic [2:0]            state_r,      state_nxt;
  logic [AW-1:0]         clr_addr_r,   clr_addr_nxt;
  logic [CW-1:0]         slot_r,       slot_nxt;
  logic [RIW-1:0]        row_r,        row_nxt;
  logic [CW-1:0]         col_r,        col_nxt;
  logic                  fill_pend_r,  fill_pend_nxt;
  logic                  filling_r,    filling_nxt;
  logic [CW-1:0]         fs_r,         fs_nxt;
  logic [CW-1:0]         o_r,          o_nxt;
  logic [PIXEL_BITS-1:0] pix_r,        pix_nxt;
  logic                  out_valid_r,  out_valid_nxt;
  logic [PIXEL_BITS-1:0] out_pix_r,    out_pix_nxt;
  logic                  out_rlast_r,  out_rlast_nxt;
  logic                  out_flast_r,  out_flast_nxt;

  logic [PIXEL_BITS-1:0] rd_q;
  logic [PIXEL_BITS-1:0] rb_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [PIXEL_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic                  rb_we;

  logic [6:0]            w7;
  logic [6:0]            slot7;
  logic [6:0]            o7;
  logic [6:0]            rs7;
  logic [6:0]            rc7;
  logic [PIXEL_BITS-1:0] black;
  logic [PIXEL_BITS-1:0] head_pix;
  logic                  frame_start;
  logic                  fill_now;
  logic                  row_end;
  logic                  frame_end;
  logic                  col_last;

  assign w7          = cfg_i.width;
  assign slot7       = 7'(slot_r);
  assign o7          = 7'(o_r);
  assign black       = (cfg_i.fmt == FMT_YUV) ? PIXEL_BITS'(YUV_BLACK) : '0;
  assign head_pix    = PIXEL_BITS'(q_head_i.pixel);
  assign frame_start = (row_r == '0) && (col_r == '0);
  assign fill_now    = frame_start ? fill_pend_r : filling_r;
  assign row_end     = (7'(col_r) + 7'd1) >= w7;
  assign frame_end   = (32'(row_r) + 32'd1) >= 32'(cfg_i.height);
  assign col_last    = (o7 + 7'd1) == w7;

  // Source slot and column of output column o for both time mappings.
  always_comb begin
    if (cfg_i.mode) begin
      rs7 = (slot7 >= o7) ? (slot7 - o7) : (slot7 + w7 - o7);
      rc7 = o7;
    end else begin
      rs7 = w7 - 7'd1 - o7;
      rc7 = slot7 + 7'd1 + o7;
      if (rc7 >= w7) begin
        rc7 = rc7 - w7;
      end
    end
  end

  assign mem_raddr = st_addr(CW'(rs7), row_r, CW'(rc7));

  // Sequencer: clearing sweep, pixel writes, fill writes and row read-out.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    slot_nxt      = slot_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    fill_pend_nxt = fill_pend_r;
    filling_nxt   = filling_r;
    fs_nxt        = fs_r;
    o_nxt         = o_r;
    pix_nxt       = pix_r;
    out_valid_nxt = out_valid_r && !out_ready_i;
    out_pix_nxt   = out_pix_r;
    out_rlast_nxt = out_rlast_r;
    out_flast_nxt = out_flast_r;
    mem_we        = 1'b0;
    mem_waddr     = st_addr(slot_r, row_r, col_r);
    mem_wdata     = head_pix;
    mem_re        = 1'b0;
    rb_we         = 1'b0;
    q_pop_o       = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = black;
        // Bring the frame slot back under the width, one subtraction a cycle.
        if (slot7 >= w7) begin
          slot_nxt = CW'(slot7 - w7);
        end
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          case (q_head_i.cmd)
            CMD_CLEAR: begin
              state_nxt    = ST_CLEAR;
              clr_addr_nxt = '0;
            end
            CMD_FILL: begin
              fill_pend_nxt = 1'b1;
            end
            CMD_PIXEL: begin
              if (frame_start) begin
                fill_pend_nxt = 1'b0;
              end
              filling_nxt = fill_now;
              pix_nxt     = head_pix;
              rb_we       = 1'b1;
              mem_we      = 1'b1;
              if (fill_now) begin
                mem_waddr = st_addr('0, row_r, col_r);
              end
              if (fill_now && (w7 > 7'd1)) begin
                fs_nxt    = CW'(1);
                state_nxt = ST_FILL;
              end else if (row_end) begin
                o_nxt     = '0;
                state_nxt = ST_RD;
              end else begin
                col_nxt = col_r + CW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = st_addr(fs_r, row_r, col_r);
        mem_wdata = pix_r;
        if ((7'(fs_r) + 7'd1) >= w7) begin
          if (row_end) begin
            o_nxt     = '0;
            state_nxt = ST_RD;
          end else begin
            col_nxt   = col_r + CW'(1);
            state_nxt = ST_IDLE;
          end
        end else begin
          fs_nxt = fs_r + CW'(1);
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (!out_valid_r || out_ready_i) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = (cfg_i.fmt == FMT_PASS) ? rb_q : rd_q;
          out_rlast_nxt = col_last;
          out_flast_nxt = col_last && frame_end;
          if (col_last) begin
            col_nxt   = '0;
            state_nxt = ST_IDLE;
            if (frame_end) begin
              row_nxt     = '0;
              slot_nxt    = ((slot7 + 7'd1) >= w7) ? '0 : (slot_r + CW'(1));
              filling_nxt = 1'b0;
            end else begin
              row_nxt = row_r + RIW'(1);
            end
          end else begin
            o_nxt     = o_r + CW'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // A change of geometry or format restarts the frame and blackens the store.
    if (restart_i) begin
      state_nxt    = ST_CLEAR;
      clr_addr_nxt = '0;
      row_nxt      = '0;
      col_nxt      = '0;
      filling_nxt  = 1'b0;
      q_pop_o      = 1'b0;
      mem_we       = 1'b0;
      rb_we        = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      slot_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      fill_pend_r <= 1'b1;
      filling_r   <= 1'b0;
      fs_r        <= '0;
      o_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      slot_r      <= slot_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      fill_pend_r <= fill_pend_nxt;
      filling_r   <= filling_nxt;
      fs_r        <= fs_nxt;
      o_r         <= o_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pix_r       <= pix_nxt;
    out_pix_r   <= out_pix_nxt;
    out_rlast_r <= out_rlast_nxt;
    out_flast_r <= out_flast_nxt;
  end

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= store_mem[mem_raddr];
    end
  end

  // Row buffer holding the input pixels of the current row.
  always_ff @(posedge clk) begin
    if (rb_we) begin
      row_mem[col_r] <= head_pix;
    end
    if (mem_re) begin
      rb_q <= row_mem[o_r];
    end
  end

  assign clearing_o       = (state_r == ST_CLEAR);
  assign out_valid_o      = out_valid_r;
  assign out_pixel_o      = DATA_W'(out_pix_r);
  assign out_row_last_o   = out_rlast_r;
  assign out_frame_last_o = out_flast_r;

  // Outside a clearing pass the counters stay inside the frame geometry.
  ap_slot_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR && !restart_i) |-> (slot7 < w7 && 7'(col_r) < w7))
    else $error("frame slot or column beyond the frame width");

  ap_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR && !restart_i) |-> (32'(row_r) < 32'(cfg_i.height)))
    else $error("row counter beyond the frame height");

  ap_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD || state_r == ST_WAIT) |-> !mem_we)
    else $error("store written during row read-out");

  ap_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flast_r) |-> out_rlast_r)
    else $error("frame end flagged away from a row end");

  ap_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop_o |=> (state_r != ST_WAIT))
    else $error("queue popped while a row read-out was running");

endmodule

`default_nettype wire

/* rtl/time_x_axis_swap_video.sv */
// Pixel transaction: one store write in the back end, or one write to each slot while a fill
// frame is written to every slot.
// Row end: each result pixel takes a read and a wait state at the single store read port.
// Reset, clear commands and geometry or format changes run a clearing pass over all
// MAX_WIDTH*MAX_WIDTH*MAX_HEIGHT store words; no input is taken meanwhile.
// Reset is synchronous and active low; the registers return to 64, 64, RGBA and mode 1.
`default_nettype none

module time_x_axis_swap_video #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int PIXEL_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_opcode,
  input  wire logic [tavs_pkg::DATA_W-1:0] in_pixel_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [tavs_pkg::DATA_W-1:0]      out_pixel_out,
  output logic                             out_row_last,
  output logic                             out_frame_last,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [3:0]                  cfg_paddr,
  input  wire logic [tavs_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [tavs_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                             cfg_pready
);
  import tavs_pkg::*;

  cfg_t       regs_r;
  cfg_t       regs_nxt;
  logic       restart_r;
  logic       restart_nxt;
  logic       wr_en;
  logic [6:0] wv;
  logic [6:0] hv;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  logic       clearing;
  q_entry_t   push_entry;
  q_entry_t   q_head;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // Saturate the written geometry into the supported range.
  always_comb begin
    wv = (cfg_pwdata[6:0] == 7'd0) ? 7'd1 : cfg_pwdata[6:0];
    if (32'(wv) > MAX_WIDTH) begin
      wv = 7'(MAX_WIDTH);
    end
    hv = (cfg_pwdata[6:0] == 7'd0) ? 7'd1 : cfg_pwdata[6:0];
    if (32'(hv) > MAX_HEIGHT) begin
      hv = 7'(MAX_HEIGHT);
    end
  end

  // Register writes; a real change of geometry or format restarts the store.
  always_comb begin
    regs_nxt    = regs_r;
    restart_nxt = 1'b0;
    if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_WIDTH: begin
          regs_nxt.width = wv;
          restart_nxt    = (wv != regs_r.width);
        end
        REG_HEIGHT: begin
          regs_nxt.height = hv;
          restart_nxt     = (hv != regs_r.height);
        end
        REG_FORMAT: begin
          regs_nxt.fmt = cfg_pwdata[1:0];
          restart_nxt  = (cfg_pwdata[1:0] != regs_r.fmt);
        end
        REG_MODE: regs_nxt.mode = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.width  <= 7'(MAX_WIDTH);
      regs_r.height <= (MAX_HEIGHT < 64) ? 7'(MAX_HEIGHT) : 7'd64;
      regs_r.fmt    <= FMT_RGBA;
      regs_r.mode   <= 1'b1;
      restart_r     <= 1'b0;
    end else begin
      regs_r    <= regs_nxt;
      restart_r <= restart_nxt;
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_paddr[3:2])
      REG_WIDTH:  cfg_prdata = DATA_W'(regs_r.width);
      REG_HEIGHT: cfg_prdata = DATA_W'(regs_r.height);
      REG_FORMAT: cfg_prdata = DATA_W'(regs_r.fmt);
      REG_MODE:   cfg_prdata = DATA_W'(regs_r.mode);
      default:    cfg_prdata = '0;
    endcase
  end

  tavs_front #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .valid_i  (in_valid),
    .ready_o  (in_ready),
    .opcode_i (in_opcode),
    .pixel_i  (in_pixel_in),
    .cfg_i    (regs_r),
    .q_full_i (q_full),
    .hold_i   (clearing || restart_r),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  tavs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .rdata_o (q_head),
    .empty_o (q_empty)
  );

  tavs_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_i            (regs_r),
    .restart_i        (restart_r),
    .q_empty_i        (q_empty),
    .q_head_i         (q_head),
    .q_pop_o          (pop),
    .clearing_o       (clearing),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_pixel_o      (out_pixel_out),
    .out_row_last_o   (out_row_last),
    .out_frame_last_o (out_frame_last)
  );

endmodule

`default_nettype wire

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tavs_pkg::*;

  localparam int MAXW = 64;
  localparam int MAXH = 64;
  localparam int SLOT_WORDS = MAXW * MAXH;
  localparam int STORE_WORDS = MAXW * SLOT_WORDS;
  // A fill pixel is written to every slot, and up to QDEPTH may sit in the command queue.
  localparam int SETTLE_CYCLES = 4 * MAXW * (QDEPTH + 1);
  // The longest quiet stretch is a clearing pass, possibly restarted by a register write.
  localparam int STALL_LIMIT = 6 * STORE_WORDS;
  localparam int REPORT_LIMIT = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [DATA_W-1:0] pixel;
  } pix_txn_t;

  typedef struct packed {
    logic [DATA_W-1:0] pixel;
    logic              row_last;
    logic              frame_last;
  } out_px_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_opcode = OP_PIXEL;
  logic [DATA_W-1:0] in_pixel_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_pixel_out;
  logic              out_row_last;
  logic              out_frame_last;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [3:0]        cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  // Stimulus waiting for the driver and swapped pixels waiting for the output.
  pix_txn_t    pixel_txn_q[$];
  out_px_t     swapped_px_q[$];
  out_px_t     want_px;
  int unsigned err_count = 0;
  int unsigned send_gap_pct = 21;
  int unsigned recv_gap_pct = 58;

  // Own copy of the frame history, the current row and the configuration.
  logic [DATA_W-1:0] history_store[STORE_WORDS];
  logic [DATA_W-1:0] line_in[MAXW];
  int unsigned       cur_slot, cur_row, cur_col;
  int unsigned       geom_w, geom_h;
  logic [1:0]        fmt_sel;
  logic              rel_mode;
  bit                fill_armed, fill_active;

  time_x_axis_swap_video dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_row_last   (out_row_last),
    .out_frame_last (out_frame_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned hist_idx(int unsigned slot, int unsigned row,
                                           int unsigned col);
    return (slot % MAXW) * SLOT_WORDS + (row % MAXH) * MAXW + (col % MAXW);
  endfunction

  // Black is zero except in YUV, where chroma sits at mid scale.
  function automatic void blacken_history();
    logic [DATA_W-1:0] blk;
    blk = (fmt_sel == FMT_YUV) ? YUV_BLACK : '0;
    foreach (history_store[i]) history_store[i] = blk;
  endfunction

  function automatic void restart_frame();
    blacken_history();
    cur_row = 0;
    cur_col = 0;
    cur_slot = cur_slot % geom_w;
    fill_active = 1'b0;
  endfunction

  function automatic int unsigned clamp_dim(logic [6:0] raw, int unsigned lim);
    if (raw < 1) return 1;
    if (raw > lim) return lim;
    return 32'(raw);
  endfunction

  // Works out the swapped row that an accepted transaction completes, if any.
  function automatic void predict_swap(logic [1:0] op, logic [DATA_W-1:0] raw);
    logic [DATA_W-1:0] msk;
    logic [DATA_W-1:0] val;
    int unsigned       o;
    out_px_t           r;
    case (fmt_sel)
      FMT_GREY: msk = 32'h0000_00FF;
      FMT_YUV:  msk = 32'h0000_FFFF;
      default:  msk = '1;
    endcase
    if (op == OP_CLEAR) begin
      blacken_history();
      return;
    end
    if (op == OP_FILL) begin
      fill_armed = 1'b1;
      return;
    end
    if (op != OP_PIXEL) return;

    // A pending fill is taken up by the first pixel of a frame.
    if (cur_row == 0 && cur_col == 0) begin
      fill_active = fill_armed;
      fill_armed = 1'b0;
    end
    line_in[cur_col % MAXW] = raw;
    if (fill_active) begin
      for (int unsigned s = 0; s < geom_w; s++)
        history_store[hist_idx(s, cur_row, cur_col)] = raw & msk;
    end else begin
      history_store[hist_idx(cur_slot, cur_row, cur_col)] = raw & msk;
    end

    if (cur_col + 1 >= geom_w) begin
      for (o = 0; o < geom_w; o++) begin
        if (fmt_sel == FMT_PASS)
          val = line_in[o % MAXW];
        else if (rel_mode)
          val = history_store[hist_idx((cur_slot + geom_w - o) % geom_w, cur_row, o)];
        else
          val = history_store[hist_idx(geom_w - 1 - o, cur_row,
                                       (cur_slot + 1 + o) % geom_w)];
        r.pixel = val & msk;
        r.row_last = (o + 1 == geom_w);
        r.frame_last = (o + 1 == geom_w) && (cur_row + 1 >= geom_h);
        swapped_px_q.push_back(r);
      end
      cur_col = 0;
      cur_row++;
      if (cur_row >= geom_h) begin
        cur_row = 0;
        cur_slot = (cur_slot + 1) % geom_w;
        fill_active = 1'b0;
      end
    end else begin
      cur_col++;
    end
  endfunction

  // Register write over the configuration port, then the same update in the predictor.
  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    int unsigned v;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_WIDTH: begin
        v = clamp_dim(value[6:0], MAXW);
        if (v != geom_w) begin
          geom_w = v;
          restart_frame();
        end
      end
      REG_HEIGHT: begin
        v = clamp_dim(value[6:0], MAXH);
        if (v != geom_h) begin
          geom_h = v;
          restart_frame();
        end
      end
      REG_FORMAT: begin
        if (value[1:0] != fmt_sel) begin
          fmt_sel = value[1:0];
          restart_frame();
        end
      end
      default: begin
        rel_mode = value[0];
      end
    endcase
  endtask

  task automatic setup_phase(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h,
                             input logic [1:0] f, input logic m,
                             input int unsigned sgap, input int unsigned rgap);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_FORMAT, {30'd0, f});
    cfg_write(REG_MODE, {31'd0, m});
    send_gap_pct = sgap;
    recv_gap_pct = rgap;
  endtask

  task automatic push_txn(input logic [1:0] op, input logic [DATA_W-1:0] pixel);
    pix_txn_t t;
    t.op = op;
    t.pixel = pixel;
    pixel_txn_q.push_back(t);
  endtask

  // Mostly pixel streams with random content, with the odd fill or unused opcode.
  // Clears are left to the directed part, as each one costs a whole clearing pass.
  task automatic queue_random(input int n);
    int unsigned roll;
    logic [1:0]  op;
    logic [DATA_W-1:0] pixel;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 3) op = OP_FILL;
      else if (roll < 5) op = OP_UNUSED;
      else op = OP_PIXEL;
      case ($urandom_range(9))
        0: pixel = '0;
        1: pixel = '1;
        default: pixel = $urandom();
      endcase
      push_txn(op, pixel);
    end
  endtask

  // Waits until every transaction is taken and every swapped pixel has arrived.
  task automatic drain_phase();
    do @(negedge clk);
    while (pixel_txn_q.size() != 0 || in_valid || swapped_px_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: one transaction per handshake, predicted on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_swap(in_opcode, in_pixel_in);
      end
      if (!in_valid || in_ready) begin
        if (pixel_txn_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_opcode <= pixel_txn_q[0].op;
          in_pixel_in <= pixel_txn_q[0].pixel;
          void'(pixel_txn_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: each accepted pixel is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (swapped_px_q.size() == 0) begin
          if (err_count < REPORT_LIMIT)
            $display("%t unexpected pixel %h row_last %b frame_last %b", $realtime,
                     out_pixel_out, out_row_last, out_frame_last);
          err_count++;
        end else begin
          want_px = swapped_px_q.pop_front();
          if (want_px.pixel !== out_pixel_out || want_px.row_last !== out_row_last ||
              want_px.frame_last !== out_frame_last) begin
            if (err_count < REPORT_LIMIT)
              $display("%t mismatch: expected %h/%b/%b, got %h/%b/%b", $realtime,
                       want_px.pixel, want_px.row_last, want_px.frame_last,
                       out_pixel_out, out_row_last, out_frame_last);
            err_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Watchdog: ends the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    // Predictor state after reset: full size, RGBA, relative mapping, fill armed.
    geom_w = MAXW;
    geom_h = MAXH;
    fmt_sel = FMT_RGBA;
    rel_mode = 1'b1;
    cur_slot = 0;
    cur_row = 0;
    cur_col = 0;
    fill_armed = 1'b1;
    fill_active = 1'b0;
    foreach (line_in[i]) line_in[i] = '0;
    blacken_history();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Small geometry for the directed part.
    setup_phase(4, 2, FMT_RGBA, 1'b1, 21, 58);

    // First frame is filled into every slot after reset; an unused opcode and a
    // fill command arrive mid-frame.
    push_txn(OP_PIXEL, 32'h0000_0000);
    push_txn(OP_PIXEL, 32'hFFFF_FFFF);
    push_txn(OP_UNUSED, 32'h1234_5678);
    push_txn(OP_PIXEL, 32'h0000_0001);
    push_txn(OP_FILL, 32'h0000_0000);
    push_txn(OP_PIXEL, 32'h8000_0000);
    push_txn(OP_PIXEL, 32'h7FFF_FFFF);
    push_txn(OP_PIXEL, 32'hFFFF_FF00);
    push_txn(OP_PIXEL, 32'h0000_00FF);
    push_txn(OP_PIXEL, 32'hAAAA_AAAA);
    // Second frame takes the armed fill and is blackened part way through.
    push_txn(OP_PIXEL, 32'h5555_5555);
    push_txn(OP_CLEAR, 32'hFFFF_FFFF);
    push_txn(OP_PIXEL, 32'h1234_5678);
    push_txn(OP_PIXEL, 32'h0F0F_0F0F);
    push_txn(OP_PIXEL, 32'hF0F0_F0F0);
    push_txn(OP_PIXEL, 32'hDEAD_BEEF);
    push_txn(OP_PIXEL, 32'h0000_0000);
    push_txn(OP_PIXEL, 32'hFFFF_FFFF);
    push_txn(OP_PIXEL, 32'h0000_8000);
    // Third frame goes to a single slot again.
    push_txn(OP_PIXEL, 32'h0000_0001);
    push_txn(OP_PIXEL, 32'h0000_0002);
    push_txn(OP_PIXEL, 32'h0000_0003);
    push_txn(OP_PIXEL, 32'h0000_0004);
    queue_random(56);
    drain_phase();

    // Width one (zero saturates up) and tall frames (over range saturates down).
    setup_phase(0, 127, FMT_GREY, 1'b0, 21, 58);
    queue_random(40);
    drain_phase();

    // Widest rows, single-row frames, YUV black in the unwritten slots.
    setup_phase(127, 0, FMT_YUV, 1'b0, 58, 21);
    queue_random(128);
    drain_phase();

    // Passthrough format still advances the store.
    setup_phase(7, 3, FMT_PASS, 1'b1, 58, 21);
    queue_random(63);
    drain_phase();

    // Back to RGBA with absolute slot mapping and no idling on either side.
    setup_phase(5, 4, FMT_RGBA, 1'b0, 0, 0);
    queue_random(60);
    drain_phase();

    err_count += swapped_px_q.size();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
